// File: rtl/mbve_pkg.sv
// ----------------------------------------------------------------------------
// mbve_pkg - shared types and constants
// Command codes, field widths and the per-byte control struct.
// ----------------------------------------------------------------------------
package mbve_pkg;

  localparam int CMD_W            = 2;
  localparam int IDX_W            = 10;
  localparam int BYTE_IDX_W       = IDX_W - 3;
  localparam int VECTOR_BYTES_DEF = 32;

  localparam logic [CMD_W-1:0] CMD_TEST   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // controls for the byte currently at the ring head
  typedef struct packed {
    logic is_target;   // byte holds the addressed bit
    logic past_target; // byte lies above the addressed byte
    logic do_set;
    logic do_delete;
  } byte_ctl_t;

endpackage

// File: rtl/mbve_byte_unit.sv
// ----------------------------------------------------------------------------
// mbve_byte_unit - one-byte update and scan step
// Applies set or delete-shift to one byte and finds its lowest set bit.
// ----------------------------------------------------------------------------
module mbve_byte_unit
  import mbve_pkg::*;
(
  input  byte_ctl_t  ctl,
  input  logic [7:0] head_byte,
  input  logic       next_lsb,
  input  logic [2:0] bit_pos,
  output logic [7:0] new_byte,
  output logic       old_bit,
  output logic       nonzero,
  output logic [2:0] low_pos
);

  logic [7:0] shifted;
  logic [7:0] mask;

  assign shifted = {next_lsb, head_byte[7:1]};
  assign mask    = 8'(1) << bit_pos;
  assign old_bit = ctl.is_target & head_byte[bit_pos];

  always_comb begin
    new_byte = head_byte;
    if (ctl.do_set && ctl.is_target) begin
      new_byte = head_byte | mask;
    end else if (ctl.do_delete && ctl.past_target) begin
      new_byte = shifted;
    end else if (ctl.do_delete && ctl.is_target) begin
      for (int j = 0; j < 8; j++) begin
        new_byte[j] = (3'(j) < bit_pos) ? head_byte[j] : shifted[j];
      end
    end
  end

  assign nonzero = |new_byte;

  always_comb begin
    low_pos = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (new_byte[j]) begin
        low_pos = 3'(j);
      end
    end
  end

endmodule

// File: rtl/match_bit_vector_engine.sv
// ----------------------------------------------------------------------------
// match_bit_vector_engine - rule-match bit vector with find-first-set
// Test, set or delete-and-shift one bit, then report the lowest set bit.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers at a rising edge with start high and busy low:
//   in_command (test, set, delete; code 3 acts as a test) and in_bit_index.
//   The vector is held as a ring of VECTOR_BYTES bytes. Each command makes
//   one full rotation of the ring, one byte per cycle, and busy stays high
//   until the last byte has been handled. During the pass each byte is updated
//   (set, or delete with the next byte's LSB shifted in) and scanned for the
//   lowest set bit.
//   The result shows for exactly one cycle with out_valid high, in the cycle
//   after the last byte; busy is already low then, so a new command may
//   transfer in that same cycle. A new command is not accepted while busy is
//   high, so each command finishes its pass before the next one starts.
//   The receiver cannot stall: a result must be taken when out_valid is high.
//   An index at or above 8*VECTOR_BYTES leaves the vector unchanged and is
//   flagged by out_index_valid low.
//   Synchronous reset (rst_n low) clears the whole vector and the control
//   state; the block is idle after reset.
// ----------------------------------------------------------------------------
module match_bit_vector_engine
  import mbve_pkg::*;
#(
  parameter int VECTOR_BYTES = VECTOR_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [CMD_W-1:0] in_command,
  input  logic [IDX_W-1:0] in_bit_index,
  output logic             out_valid,
  output logic             out_bit_was_set,
  output logic             out_index_valid,
  output logic             out_first_found,
  output logic [IDX_W-1:0] out_first_index,
  output logic             out_vector_empty
);

  localparam int NUM_BITS = 8 * VECTOR_BYTES;
  localparam int CNT_W    = (VECTOR_BYTES > 1) ? $clog2(VECTOR_BYTES) : 1;
  localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(VECTOR_BYTES - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       ring_r [VECTOR_BYTES];

  // latched command
  logic [CMD_W-1:0] cmd_r;
  logic [IDX_W-1:0] idx_r;
  logic             valid_r;

  // running results of the pass
  logic             was_r, was_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] first_r, first_nxt;

  // output registers
  logic             out_valid_r;
  logic             out_was_r;
  logic             out_ivalid_r;
  logic             out_found_r;
  logic [IDX_W-1:0] out_first_r;

  logic             accept;
  logic             last_cycle;
  logic             next_lsb;
  byte_ctl_t        ctl;
  logic [7:0]       new_byte;
  logic             old_bit;
  logic             nonzero;
  logic [2:0]       low_pos;
  logic [BYTE_IDX_W-1:0] cur_byte;

  assign busy       = (state_r == ST_RUN);
  assign accept     = start && !busy;
  assign last_cycle = busy && (cnt_r == LAST_BYTE);
  assign cur_byte   = BYTE_IDX_W'(cnt_r);

  // LSB of the byte above the head; the top byte gets a zero shifted in
  generate
    if (VECTOR_BYTES > 1) begin : g_next
      assign next_lsb = (cnt_r == LAST_BYTE) ? 1'b0 : ring_r[1][0];
    end else begin : g_single
      assign next_lsb = 1'b0;
    end
  endgenerate

  always_comb begin
    ctl.is_target   = valid_r && (cur_byte == idx_r[IDX_W-1:3]);
    ctl.past_target = valid_r && (cur_byte >  idx_r[IDX_W-1:3]);
    ctl.do_set      = (cmd_r == CMD_SET);
    ctl.do_delete   = (cmd_r == CMD_DELETE);
  end

  mbve_byte_unit u_byte (
    .ctl       (ctl),
    .head_byte (ring_r[0]),
    .next_lsb  (next_lsb),
    .bit_pos   (idx_r[2:0]),
    .new_byte  (new_byte),
    .old_bit   (old_bit),
    .nonzero   (nonzero),
    .low_pos   (low_pos)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    was_nxt   = was_r;
    found_nxt = found_r;
    first_nxt = first_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
          was_nxt   = 1'b0;
          found_nxt = 1'b0;
          first_nxt = '0;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        was_nxt = was_r | old_bit;
        if (!found_r && nonzero) begin
          found_nxt = 1'b1;
          first_nxt = {cur_byte, low_pos};
        end
        if (last_cycle) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < VECTOR_BYTES; i++) begin
        ring_r[i] <= 8'd0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= last_cycle;
      if (busy) begin
        for (int i = 0; i < VECTOR_BYTES - 1; i++) begin
          ring_r[i] <= ring_r[i+1];
        end
        ring_r[VECTOR_BYTES-1] <= new_byte;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    was_r   <= was_nxt;
    found_r <= found_nxt;
    first_r <= first_nxt;
    if (accept) begin
      cmd_r   <= in_command;
      idx_r   <= in_bit_index;
      valid_r <= ({1'b0, in_bit_index} < (IDX_W+1)'(NUM_BITS));
    end
    if (last_cycle) begin
      out_was_r    <= was_nxt;
      out_ivalid_r <= valid_r;
      out_found_r  <= found_nxt;
      out_first_r  <= first_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bit_was_set  = out_was_r;
  assign out_index_valid  = out_ivalid_r;
  assign out_first_found  = out_found_r;
  assign out_first_index  = out_first_r;
  assign out_vector_empty = !out_found_r;

`ifndef SYNTH
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command transfer did not start a pass");

  a_strobe_after_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result without a finished pass");

  a_invalid_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_index_valid) |-> !out_bit_was_set)
    else $error("out-of-range index reported a set bit");

  a_first_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_first_found) |-> ({1'b0, out_first_index} < (IDX_W+1)'(NUM_BITS)))
    else $error("lowest set bit beyond vector");
`endif

endmodule
